>>> hw/rtl/fmvs_pkg.sv
// Shared types, codes and constants of the Fourier mode velocity synthesizer.
package fmvs_pkg;

	localparam int WORDS_PER_MODE = 9;
	localparam longint TWO_PI_Q32 = 64'sd26986075409;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic [31:0] SIN_A1 = 32'd1686629713;
	localparam logic [31:0] SIN_A3 = 32'd693598668;
	localparam logic [31:0] SIN_A5 = 32'd85569306;
	localparam logic [31:0] SIN_A7 = 32'd5026995;
	localparam logic [31:0] SIN_A9 = 32'd172273;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MODES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ = 1'b1;

	localparam logic [3:0] OP_UT = 4'd0;
	localparam logic [3:0] OP_KE = 4'd1;
	localparam logic [3:0] OP_WT = 4'd2;
	localparam logic [3:0] OP_FT = 4'd3;
	localparam logic [3:0] OP_PH = 4'd4;
	localparam logic [3:0] OP_DIV = 4'd5;
	localparam logic [3:0] OP_Z2 = 4'd6;
	localparam logic [3:0] OP_POLY = 4'd7;
	localparam logic [3:0] OP_PZ = 4'd8;
	localparam logic [3:0] OP_AC = 4'd9;
	localparam logic [3:0] OP_SD = 4'd10;

	localparam logic [4:0] STEP_LAST_UT = 5'd2;
	localparam logic [4:0] STEP_FIRST_MODE = 5'd3;
	localparam logic [4:0] STEP_LAST = 5'd19;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] axis;
		logic [3:0] word;
	} step_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] axis;
		logic [3:0] word;
		logic       eval_start;
		logic       load_we;
		logic       ram_re;
		logic       mul_en;
		logic       wb_en;
		logic       div_start;
		logic       base_clr;
		logic       base_adv;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic step_t step_info(input logic [4:0] stp);
		step_t s;
		s = '{op: OP_UT, axis: 2'd0, word: 4'd0};
		case (stp)
			5'd0: s = '{op: OP_UT, axis: 2'd0, word: 4'd0};
			5'd1: s = '{op: OP_UT, axis: 2'd1, word: 4'd0};
			5'd2: s = '{op: OP_UT, axis: 2'd2, word: 4'd0};
			5'd3: s = '{op: OP_KE, axis: 2'd0, word: 4'd0};
			5'd4: s = '{op: OP_KE, axis: 2'd1, word: 4'd1};
			5'd5: s = '{op: OP_KE, axis: 2'd2, word: 4'd2};
			5'd6: s = '{op: OP_WT, axis: 2'd0, word: 4'd8};
			5'd7: s = '{op: OP_FT, axis: 2'd0, word: 4'd0};
			5'd8: s = '{op: OP_PH, axis: 2'd0, word: 4'd7};
			5'd9: s = '{op: OP_DIV, axis: 2'd0, word: 4'd0};
			5'd10: s = '{op: OP_Z2, axis: 2'd0, word: 4'd0};
			5'd11: s = '{op: OP_POLY, axis: 2'd0, word: 4'd0};
			5'd12: s = '{op: OP_POLY, axis: 2'd1, word: 4'd0};
			5'd13: s = '{op: OP_POLY, axis: 2'd2, word: 4'd0};
			5'd14: s = '{op: OP_POLY, axis: 2'd3, word: 4'd0};
			5'd15: s = '{op: OP_PZ, axis: 2'd0, word: 4'd0};
			5'd16: s = '{op: OP_AC, axis: 2'd0, word: 4'd6};
			5'd17: s = '{op: OP_SD, axis: 2'd0, word: 4'd3};
			5'd18: s = '{op: OP_SD, axis: 2'd1, word: 4'd4};
			5'd19: s = '{op: OP_SD, axis: 2'd2, word: 4'd5};
			default: s = '{op: OP_UT, axis: 2'd0, word: 4'd0};
		endcase
		return s;
	endfunction

	function automatic logic [31:0] sin_coef(input logic [1:0] idx);
		logic [31:0] c;
		case (idx)
			2'd0: c = SIN_A7;
			2'd1: c = SIN_A5;
			2'd2: c = SIN_A3;
			default: c = SIN_A1;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/fmvs_ram.sv
// Generic single write, single read RAM with registered read data.
module fmvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 576
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/fmvs_turn.sv
// Angle reduction modulo 2pi and turn fraction by long division with the constant 2pi.
module fmvs_turn import fmvs_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int AW = 51
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] ang,
	output logic                 done,
	output logic [30:0]          z,
	output logic                 cneg
);

	localparam longint TWO_PI_QF =
		(TWO_PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
	localparam int DW = $clog2(TWO_PI_QF + 1);
	localparam int SH = DW - 1;
	localparam int TW = DW + 16;
	localparam int ND = (AW + 48) / 16;
	localparam int NW = ND * 16;
	localparam int CNTW = $clog2(ND);
	localparam logic [DW-1:0] DIVISOR = DW'(TWO_PI_QF);
	localparam logic [DW+1:0] DIV1 = {2'b00, DIVISOR};
	localparam logic [DW+1:0] DIV2 = {1'b0, DIVISOR, 1'b0};
	localparam logic [AW:0] OFFSET = {{(AW + 1 - DW){1'b0}}, DIVISOR} << (AW - DW);
	localparam logic [17:0] RECIP = 18'((64'sd1 <<< (SH + 17)) / TWO_PI_QF);

	localparam logic [1:0] P_EST = 2'd0;
	localparam logic [1:0] P_REM = 2'd1;
	localparam logic [1:0] P_FIX = 2'd2;

	logic            busy_q;
	logic            done_q;
	logic [1:0]      phase_q;
	logic [CNTW-1:0] dig_q;
	logic [NW-1:0]   num_q;
	logic [DW-1:0]   r_q;
	logic [15:0]     qe_q;
	logic [DW+1:0]   rem_q;
	logic [31:0]     q_q;
	logic [AW:0]     u;
	logic [TW-1:0]   t;
	logic [34:0]     est;
	logic [TW-1:0]   qd_prod;
	logic [TW-1:0]   rem_nx;
	logic [DW-1:0]   r_fix;
	logic [1:0]      q_inc;
	logic [31:0]     ph;

	// shift the angle by a multiple of 2pi so the dividend is never negative
	assign u = {ang[AW-1], ang} + OFFSET;
	assign t = {r_q, num_q[NW-1 -: 16]};
	assign est = 35'(t[TW-1:SH]) * 35'(RECIP);
	assign qd_prod = TW'(qe_q) * TW'(DIVISOR);
	assign rem_nx = t - qd_prod;

	always_comb begin
		if (rem_q >= DIV2) begin
			r_fix = DW'(rem_q - DIV2);
			q_inc = 2'd2;
		end else if (rem_q >= DIV1) begin
			r_fix = DW'(rem_q - DIV1);
			q_inc = 2'd1;
		end else begin
			r_fix = rem_q[DW-1:0];
			q_inc = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= P_EST;
			dig_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= P_EST;
				dig_q <= CNTW'(ND - 1);
			end else if (busy_q) begin
				if (phase_q == P_FIX) begin
					phase_q <= P_EST;
					if (dig_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						dig_q <= dig_q - 1'b1;
					end
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(u) << 32;
			r_q <= '0;
		end else if (busy_q) begin
			case (phase_q)
				P_EST: qe_q <= est[32:17];
				P_REM: rem_q <= rem_nx[DW+1:0];
				P_FIX: begin
					r_q <= r_fix;
					q_q <= {q_q[15:0], qe_q + 16'(q_inc)};
					num_q <= {num_q[NW-17:0], 16'h0};
				end
				default: ;
			endcase
		end
	end

	assign ph = q_q + 32'h4000_0000;
	assign z = ph[30] ? ONE_Q30 - {1'b0, ph[29:0]} : {1'b0, ph[29:0]};
	assign cneg = ph[31];
	assign done = done_q;

endmodule

>>> hw/rtl/fmvs_dpath.sv
// Datapath: mode table, shared multiplier, angle unit and saturating accumulators.
module fmvs_dpath import fmvs_pkg::*; #(
	parameter int MAX_MODES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [5:0]           mode_index,
	input  logic [3:0]           word_select,
	input  logic signed [31:0]   word_value,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic signed [31:0]   mean_vel_x,
	input  logic signed [31:0]   mean_vel_y,
	input  logic signed [31:0]   mean_vel_z,
	input  logic signed [31:0]   time_value,
	output logic signed [31:0]   turb_vel_x,
	output logic signed [31:0]   turb_vel_y,
	output logic signed [31:0]   turb_vel_z
);

	localparam int DEPTH = WORDS_PER_MODE * MAX_MODES;
	localparam int RAW = $clog2(DEPTH);
	localparam int AW = 67 - FRAC_BITS;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -65'sh0_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	logic signed [31:0] x_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] e_q [3];
	logic signed [31:0] acc_q [3];
	logic signed [31:0] tv_q [3];
	logic signed [31:0] t_q;
	logic signed [31:0] ff_q;
	logic signed [31:0] wt_q;
	logic signed [31:0] cos_q;
	logic signed [31:0] s_q;
	logic signed [AW-1:0] kx_q;
	logic signed [AW-1:0] ang_q;
	logic [30:0]        pz_q;
	logic [30:0]        z2_q;
	logic [RAW-1:0]     base_q;
	logic signed [63:0] prod_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] shr_f;
	logic signed [AW-1:0] pf_aw;
	logic signed [31:0] rd;
	logic [31:0]        ram_rdata;
	logic [RAW-1:0]     waddr;
	logic [RAW-1:0]     raddr;
	logic               wr_ok;
	logic [31:0]        pzv;
	logic [31:0]        cmag;
	logic               turn_done;
	logic [30:0]        tz;
	logic               tneg;

	assign wr_ok = cmd.load_we && (32'(mode_index) < MAX_MODES)
		&& (32'(word_select) < WORDS_PER_MODE);
	assign waddr = RAW'(32'(mode_index) * WORDS_PER_MODE + 32'(word_select));
	assign raddr = base_q + RAW'(cmd.word);
	assign rd = signed'(ram_rdata);

	fmvs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (waddr),
		.wdata (word_value),
		.re    (cmd.ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	fmvs_turn #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.ang    (ang_q),
		.done   (turn_done),
		.z      (tz),
		.cneg   (tneg)
	);

	assign sts.div_done = turn_done;

	always_comb begin
		mul_a = rd;
		mul_b = t_q;
		case (cmd.op)
			OP_UT: begin
				mul_a = u_q[cmd.axis];
				mul_b = t_q;
			end
			OP_KE: begin
				mul_a = rd;
				mul_b = e_q[cmd.axis];
			end
			OP_WT: begin
				mul_a = rd;
				mul_b = t_q;
			end
			OP_FT: begin
				mul_a = ff_q;
				mul_b = wt_q;
			end
			OP_Z2: begin
				mul_a = signed'({1'b0, tz});
				mul_b = signed'({1'b0, tz});
			end
			OP_POLY: begin
				mul_a = signed'({1'b0, pz_q});
				mul_b = signed'({1'b0, z2_q});
			end
			OP_PZ: begin
				mul_a = signed'({1'b0, pz_q});
				mul_b = signed'({1'b0, tz});
			end
			OP_AC: begin
				mul_a = rd;
				mul_b = cos_q;
			end
			OP_SD: begin
				mul_a = rd;
				mul_b = s_q;
			end
			default: begin
				mul_a = rd;
				mul_b = t_q;
			end
		endcase
	end

	assign shr_f = prod_q >>> FRAC_BITS;
	assign pf_aw = AW'(shr_f);
	assign pzv = prod_q[61:30];
	assign cmag = (pzv > 32'(ONE_Q30)) ? 32'(ONE_Q30) : pzv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q <= 32'sd65536;
		end else if (cfg_we && cfg_index == REG_FREQ) begin
			ff_q <= signed'(cfg_data);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			x_q[0] <= pos_x;
			x_q[1] <= pos_y;
			x_q[2] <= pos_z;
			u_q[0] <= mean_vel_x;
			u_q[1] <= mean_vel_y;
			u_q[2] <= mean_vel_z;
			t_q <= time_value;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end
		if (cmd.base_clr) begin
			base_q <= '0;
		end else if (cmd.base_adv) begin
			base_q <= base_q + RAW'(WORDS_PER_MODE);
		end
		if (cmd.mul_en) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		if (cmd.wb_en) begin
			case (cmd.op)
				OP_UT: e_q[cmd.axis] <= sat32(65'(x_q[cmd.axis])
					- 65'(sat32(65'(shr_f))));
				OP_KE: kx_q <= (cmd.axis == 2'd0) ? pf_aw : kx_q + pf_aw;
				OP_WT: wt_q <= sat32(65'(shr_f));
				OP_FT: ang_q <= kx_q + pf_aw;
				OP_PH: ang_q <= ang_q + AW'(rd);
				OP_Z2: begin
					z2_q <= prod_q[60:30];
					pz_q <= 31'(SIN_A9);
				end
				OP_POLY: pz_q <= 31'(sin_coef(cmd.axis) - prod_q[61:30]);
				OP_PZ: cos_q <= tneg ? -signed'(cmag) : signed'(cmag);
				OP_AC: s_q <= sat32(65'(prod_q >>> 29));
				OP_SD: acc_q[cmd.axis] <= sat32(65'(acc_q[cmd.axis]) + 65'(shr_f));
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			tv_q[0] <= acc_q[0];
			tv_q[1] <= acc_q[1];
			tv_q[2] <= acc_q[2];
		end
	end

	assign turb_vel_x = tv_q[0];
	assign turb_vel_y = tv_q[1];
	assign turb_vel_z = tv_q[2];

endmodule

>>> hw/rtl/fmvs_ctrl.sv
// Controller: input handshake, step sequencer over modes, output register handshake.
module fmvs_ctrl import fmvs_pkg::*; #(
	parameter int MAX_MODES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cmd_t                 cmd,
	input  sts_t                 sts
);

	localparam int MW = $clog2(MAX_MODES + 1);
	localparam int CW = (MW > 7) ? MW : 7;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_WB = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [4:0]    stp_q;
	logic [4:0]    stp_d;
	logic [CW-1:0] mcnt_q;
	logic [CW-1:0] mcnt_d;
	logic [6:0]    miu_q;
	logic          out_valid_q;
	logic [CW-1:0] miu_ext;
	logic [CW-1:0] n_use;
	logic          advance;
	step_t         st;

	assign miu_ext = CW'(miu_q);
	assign n_use = (miu_ext > CW'(MAX_MODES)) ? CW'(MAX_MODES) : miu_ext;
	assign st = step_info(stp_q);

	always_comb begin
		cmd = '0;
		cmd.op = st.op;
		cmd.axis = st.axis;
		cmd.word = st.word;
		state_d = state_q;
		stp_d = stp_q;
		mcnt_d = mcnt_q;
		advance = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action) begin
						cmd.eval_start = 1'b1;
						cmd.base_clr = 1'b1;
						stp_d = '0;
						mcnt_d = '0;
						state_d = S_RD;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			S_RD: begin
				cmd.ram_re = 1'b1;
				if (st.op == OP_DIV) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				cmd.wb_en = 1'b1;
				advance = 1'b1;
			end
			S_DIV: begin
				advance = sts.div_done;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (advance) begin
			state_d = S_RD;
			if (stp_q == STEP_LAST_UT) begin
				stp_d = STEP_FIRST_MODE;
				if (n_use == '0) begin
					state_d = S_OUT;
				end
			end else if (stp_q == STEP_LAST) begin
				stp_d = STEP_FIRST_MODE;
				if (mcnt_q + 1'b1 == n_use) begin
					state_d = S_OUT;
				end else begin
					mcnt_d = mcnt_q + 1'b1;
					cmd.base_adv = 1'b1;
				end
			end else begin
				stp_d = stp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stp_q <= '0;
			mcnt_q <= '0;
			miu_q <= 7'd64;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stp_q <= stp_d;
			mcnt_q <= mcnt_d;
			if (cfg_we && cfg_index == REG_MODES) begin
				miu_q <= cfg_data[6:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/fourier_mode_velocity_synth_core.sv
// Top level of the random Fourier mode velocity synthesizer.
//
// Input channel (in_valid/in_ready): action 0 writes word_value into word
// word_select of mode mode_index and gives no result; action 1 evaluates the
// velocity fluctuation at the node from pos, mean_vel and time.
// Output channel (out_valid/out_ready): one item per evaluation.
// Config port: cfg_we with cfg_index 0 (modes in use) or 1 (freq factor).
// The next item can be taken from the cycle in which a result is loaded into
// the output register. Each mode runs 16 operations through the one shared
// 32x32 multiplier, each in three steps (table read, multiply, write-back),
// plus the angle reduction modulo 2pi: a start, then long division by the
// constant 2pi, 16 quotient bits per digit, each digit in three steps
// (estimate, remainder, fix), ND = (AW + 48) / 16 digits with
// AW = 67 - FRAC_BITS, i.e. 6 digits at FRAC_BITS 16.
// One item is in work at a time; loads complete in the idle state.
// Reset clears the controller and the config registers (64 modes, factor
// 1.0); the mode table holds no defined value until loaded.
// A finished result sits in the output register; while the receiver stalls,
// loads are still taken, and the next evaluation waits to hand over.
module fourier_mode_velocity_synth_core import fmvs_pkg::*; #(
	parameter int MAX_MODES = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [5:0]           mode_index,
	input  logic [3:0]           word_select,
	input  logic signed [31:0]   word_value,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic signed [31:0]   mean_vel_x,
	input  logic signed [31:0]   mean_vel_y,
	input  logic signed [31:0]   mean_vel_z,
	input  logic signed [31:0]   time_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   turb_vel_x,
	output logic signed [31:0]   turb_vel_y,
	output logic signed [31:0]   turb_vel_z,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fmvs_ctrl #(.MAX_MODES(MAX_MODES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fmvs_dpath #(.MAX_MODES(MAX_MODES), .FRAC_BITS(FRAC_BITS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode_index  (mode_index),
		.word_select (word_select),
		.word_value  (word_value),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.mean_vel_x  (mean_vel_x),
		.mean_vel_y  (mean_vel_y),
		.mean_vel_z  (mean_vel_z),
		.time_value  (time_value),
		.turb_vel_x  (turb_vel_x),
		.turb_vel_y  (turb_vel_y),
		.turb_vel_z  (turb_vel_z)
	);

endmodule

>>> hw/rtl/fmvs_checker.sv
// Port-level checker of the velocity synthesizer and its bind to the top level.
module fmvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] turb_vel_x,
	input logic [31:0] turb_vel_y,
	input logic [31:0] turb_vel_z
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(turb_vel_x) && $stable(turb_vel_y)
			&& $stable(turb_vel_z))
		else $error("result item changed while stalled");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action |=> !in_ready)
		else $error("item taken during evaluation");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !action |=> in_ready)
		else $error("load item did not finish in one cycle");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind fourier_mode_velocity_synth_core fmvs_checker u_fmvs_checker (.*);

>>> test/fourier_mode_velocity_synth_core_tb.sv
// Testbench for the Fourier mode velocity synthesizer: random and directed items, scoreboard check.
`timescale 1ns / 100ps

module fourier_mode_velocity_synth_core_tb;
	import fmvs_pkg::*;

	localparam int FRAC = 16;
	localparam int NMODES = 64;
	localparam longint TWO_PI_QF = (TWO_PI_Q32 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
	localparam longint UNIT_Q30 = 64'sd1 <<< 30;
	localparam longint COEF_A9 = 172273;
	localparam bit ACT_LOAD = 1'b0;
	localparam bit ACT_EVAL = 1'b1;
	localparam logic [3:0] WS_AMP = 4'd6;

	typedef struct packed {
		logic act;
		logic [5:0] idx;
		logic [3:0] ws;
		logic signed [31:0] val;
		logic signed [31:0] px, py, pz;
		logic signed [31:0] ux, uy, uz;
		logic signed [31:0] t;
	} in_item_t;

	typedef struct {
		longint vx, vy, vz;
	} vel_t;

	class vel_scoreboard;
		longint mode_tbl[WORDS_PER_MODE * NMODES];
		int unsigned n_modes;
		longint fa;
		vel_t expected_q[$];
		int errors;

		function new();
			foreach (mode_tbl[i]) mode_tbl[i] = 0;
			n_modes = 64;
			fa = 65536;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
			if (idx == REG_MODES) n_modes = d[6:0];
			else fa = longint'(signed'(d));
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint sine_quarter(longint z);
			bit [63:0] zu, z2, p;
			longint ps;
			zu = z;
			z2 = (zu * zu) >> 30;
			p = COEF_A9;
			p = 64'(SIN_A7) - ((p * z2) >> 30);
			p = 64'(SIN_A5) - ((p * z2) >> 30);
			p = 64'(SIN_A3) - ((p * z2) >> 30);
			p = 64'(SIN_A1) - ((p * z2) >> 30);
			p = (p * zu) >> 30;
			ps = p;
			return ps > UNIT_Q30 ? UNIT_Q30 : ps;
		endfunction

		function longint cos_q30(longint ang);
			longint r, z, s;
			bit [63:0] ru, turn;
			bit [31:0] ph;
			r = ang % TWO_PI_QF;
			if (r < 0) r += TWO_PI_QF;
			ru = r;
			turn = (ru << 32) / 64'(TWO_PI_QF);
			ph = turn[31:0] + 32'h4000_0000;
			z = ph[30] ? UNIT_Q30 - longint'(ph[29:0]) : longint'(ph[29:0]);
			s = sine_quarter(z);
			return ph[31] ? -s : s;
		endfunction

		function vel_t synth_velocity(in_item_t it);
			longint pos[3], mv[3], e[3], acc[3];
			longint t, kx, wt, ft, s;
			int unsigned n, b;
			vel_t v;
			pos = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
			mv = '{longint'(it.ux), longint'(it.uy), longint'(it.uz)};
			t = it.t;
			acc = '{0, 0, 0};
			for (int a = 0; a < 3; a++)
				e[a] = sat32(pos[a] - sat32((mv[a] * t) >>> FRAC));
			n = n_modes > NMODES ? NMODES : n_modes;
			for (int m = 0; m < n; m++) begin
				b = m * WORDS_PER_MODE;
				kx = 0;
				for (int a = 0; a < 3; a++)
					kx += (mode_tbl[b + a] * e[a]) >>> FRAC;
				wt = sat32((mode_tbl[b + 8] * t) >>> FRAC);
				ft = (fa * wt) >>> FRAC;
				s = sat32((mode_tbl[b + 6] * cos_q30(kx + mode_tbl[b + 7] + ft)) >>> 29);
				for (int a = 0; a < 3; a++)
					acc[a] = sat32(acc[a] + ((s * mode_tbl[b + 3 + a]) >>> FRAC));
			end
			v.vx = acc[0];
			v.vy = acc[1];
			v.vz = acc[2];
			return v;
		endfunction

		function void note_item(in_item_t it);
			if (it.act == ACT_LOAD) begin
				if (it.ws < WORDS_PER_MODE)
					mode_tbl[it.idx * WORDS_PER_MODE + it.ws] = longint'(it.val);
			end else begin
				expected_q = {expected_q, synth_velocity(it)};
			end
		endfunction

		function void check_result(longint gx, longint gy, longint gz);
			vel_t ex;
			if (expected_q.size() == 0) begin
				$error("unexpected result x=%0d y=%0d z=%0d", gx, gy, gz);
				errors++;
				return;
			end
			ex = expected_q.pop_front();
			if (gx != ex.vx) begin
				$error("turb_vel_x expected %0d actual %0d", ex.vx, gx);
				errors++;
			end
			if (gy != ex.vy) begin
				$error("turb_vel_y expected %0d actual %0d", ex.vy, gy);
				errors++;
			end
			if (gz != ex.vz) begin
				$error("turb_vel_z expected %0d actual %0d", ex.vz, gz);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] turb_vel_x, turb_vel_y, turb_vel_z;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	in_item_t cur = '0;

	vel_scoreboard sb = new();
	int results_seen = 0;
	int burst_left = 1;

	fourier_mode_velocity_synth_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(cur.act), .mode_index(cur.idx), .word_select(cur.ws), .word_value(cur.val),
		.pos_x(cur.px), .pos_y(cur.py), .pos_z(cur.pz),
		.mean_vel_x(cur.ux), .mean_vel_y(cur.uy), .mean_vel_z(cur.uz),
		.time_value(cur.t),
		.out_valid(out_valid), .out_ready(out_ready),
		.turb_vel_x(turb_vel_x), .turb_vel_y(turb_vel_y), .turb_vel_z(turb_vel_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_item(cur);
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(longint'(turb_vel_x), longint'(turb_vel_y), longint'(turb_vel_z));
			results_seen++;
		end
	end

	// receiver: rotates between always ready and two random stall patterns, with one long hold after 20 results
	initial begin
		int hold_left, cyc;
		bit held;
		hold_left = 0;
		cyc = 0;
		held = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && results_seen == 20) begin
				held = 1;
				hold_left = 4000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((cyc / 300) % 3)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	function automatic in_item_t load_item(logic [5:0] idx, logic [3:0] ws, logic [31:0] v);
		in_item_t it;
		it = '0;
		it.act = ACT_LOAD;
		it.idx = idx;
		it.ws = ws;
		it.val = v;
		it.px = $urandom;
		it.t = $urandom;
		return it;
	endfunction

	function automatic in_item_t eval_item();
		in_item_t it;
		it.act = ACT_EVAL;
		it.idx = 6'($urandom);
		it.ws = 4'($urandom);
		it.val = $urandom;
		it.px = rand_word();
		it.py = rand_word();
		it.pz = rand_word();
		it.ux = rand_word();
		it.uy = rand_word();
		it.uz = rand_word();
		it.t = rand_word();
		return it;
	endfunction

	function automatic in_item_t fill_eval(logic [31:0] v);
		in_item_t it;
		it = eval_item();
		it.px = v;
		it.py = v;
		it.pz = v;
		it.ux = v;
		it.uy = v;
		it.uz = v;
		it.t = v;
		return it;
	endfunction

	task automatic put_item(in_item_t it);
		in_valid <= 1'b1;
		cur <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#50_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// define every table word before any evaluation
		for (int m = 0; m < NMODES; m++)
			for (int w = 0; w < WORDS_PER_MODE; w++)
				put_item(load_item(6'(m), 4'(w), rand_word()));

		wait_idle();
		write_reg(REG_MODES, 32'd2);
		write_reg(REG_FREQ, 32'd65536);
		put_item(load_item(6'd0, WS_AMP, 32'h7fff_ffff));
		put_item(load_item(6'd1, WS_AMP, 32'h8000_0000));
		put_item(load_item(6'd0, 4'd0, 32'h8000_0000));
		put_item(load_item(6'd0, 4'd3, 32'h7fff_ffff));
		put_item(load_item(6'd1, 4'd5, 32'h8000_0000));
		put_item(load_item(6'd63, 4'd8, 32'h7fff_ffff));
		put_item(load_item(6'd5, 4'd9, 32'h1234_5678));
		put_item(load_item(6'd5, 4'd15, 32'hffff_ffff));
		put_item(fill_eval(32'h0));
		put_item(fill_eval(32'h8000_0000));
		put_item(fill_eval(32'h7fff_ffff));
		put_item(fill_eval(32'hffff_ffff));
		put_item(eval_item());

		wait_idle();
		write_reg(REG_MODES, 32'd0);
		put_item(eval_item());
		wait_idle();
		write_reg(REG_MODES, 32'd127);
		write_reg(REG_FREQ, 32'h8000_0000);
		put_item(eval_item());
		wait_idle();
		write_reg(REG_MODES, 32'd64);
		write_reg(REG_FREQ, 32'h7fff_ffff);
		put_item(eval_item());
		wait_idle();
		write_reg(REG_MODES, 32'd1);
		write_reg(REG_FREQ, 32'h0);
		put_item(eval_item());
		put_item(eval_item());

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_reg(REG_MODES, $urandom_range(1, 6));
			write_reg(REG_FREQ, rand_word());
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 1) == 1)
					put_item(eval_item());
				else
					put_item(load_item(6'($urandom), 4'($urandom_range(0, 15)), rand_word()));
			end
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/fmvs_pkg.sv
hw/rtl/fmvs_ram.sv
hw/rtl/fmvs_turn.sv
hw/rtl/fmvs_dpath.sv
hw/rtl/fmvs_ctrl.sv
hw/rtl/fourier_mode_velocity_synth_core.sv
hw/rtl/fmvs_checker.sv
test/fourier_mode_velocity_synth_core_tb.sv
